>>> sv/wss_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the wave stencil step unit.
// No dependencies; used by wave_stencil_step_unit and wss_port_checker.
package wss_pkg;

   localparam int MAX_GRID         = 512;
   localparam int ADDR_W           = $clog2(MAX_GRID);
   localparam int GRID_W           = 10;
   localparam int GRID_MIN         = 16;
   localparam int HEIGHT_W         = 16;
   localparam int HEIGHT_FRAC_BITS = 12;
   localparam int HEIGHT_LIMIT     = 4 << HEIGHT_FRAC_BITS;

   localparam int TENSION_W   = 15;
   localparam int TENSION_MIN = 11796;
   localparam int TENSION_MAX = 30802;
   localparam int DAMPING_W   = 16;

   localparam int GRID_RESET    = 128;
   localparam int TENSION_RESET = 19661;
   localparam int DAMPING_RESET = 64881;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TENSION   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMPING   = 2'd2;

   // Reciprocal of three, exact floor for operands below 2^23
   localparam int RECIP3_SHIFT = 24;
   localparam int RECIP3       = 5592406;

   // Line buffer word: {row0 height, row1 height, delayed previous height}
   localparam int WORD_W = 3 * HEIGHT_W;

endpackage

>>> sv/wave_stencil_step_unit.sv
`timescale 1ns / 1ps
// Wave stencil step unit: one damped wave substep over a raster cell stream.
// Depends on wss_pkg.
//
// Usage notes
// - Request channel (req_*): one cell per request in raster order, with its
//   current and previous height; req_frame_start marks cell (0,0).
// - Response channel (rsp_*): new height of the cell one row plus one cell
//   behind the request. The first grid_size+1 cells of a frame give no
//   response; the consumer supplies the trailing border zeros itself.
// - Config port (csr_*): single-cycle writes, only while the unit is idle.
// - Timing: one request at a time. A request that gives a response passes
//   through WIN, SUM, MUL, SCALE, DIV and OUT to the response register; one
//   that gives none returns to idle after WIN. The steps are set by the line
//   buffer read-modify-write (registered read) and the multiply chain after it.
// - A finished response sits in the output register; a new request is taken
//   meanwhile. A stalled receiver holds the unit only at its last step.
// - Reset clears counters, window, config and the fill count. The line
//   buffer is not cleared: entries beyond the fill count read as zero.

module wave_stencil_step_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [wss_pkg::HEIGHT_W-1:0]  req_cur_height,
   input  logic signed [wss_pkg::HEIGHT_W-1:0]  req_prev_height,
   input  logic                                 req_frame_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [wss_pkg::HEIGHT_W-1:0]  rsp_next_height,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_wr_en,
   input  logic [wss_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wss_pkg::CSR_DATA_W-1:0]       csr_wr_data
);

   localparam int AW = wss_pkg::ADDR_W;
   localparam int GW = wss_pkg::GRID_W;
   localparam int HW = wss_pkg::HEIGHT_W;

   // sequencer codes
   localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request
   localparam logic [2:0] S_WIN   = 3'd1;  // buffer data back: window, products
   localparam logic [2:0] S_SUM   = 3'd2;  // accumulate
   localparam logic [2:0] S_MUL   = 3'd3;  // damping multiply
   localparam logic [2:0] S_SCALE = 3'd4;  // rounding shift
   localparam logic [2:0] S_DIV   = 3'd5;  // divide by three
   localparam logic [2:0] S_OUT   = 3'd6;  // saturate, load response

   localparam logic signed [54:0] ROUND_BIAS = 55'sd3 <<< 32;
   localparam logic signed [23:0] DIV_OFFSET = 24'sd6291456;  // 3 * 2^21
   localparam logic signed [22:0] DIV_BASE   = 23'sd2097152;  // 2^21
   localparam logic signed [22:0] SAT_HI     = 23'(wss_pkg::HEIGHT_LIMIT);
   localparam logic signed [22:0] SAT_LO     = -23'(wss_pkg::HEIGHT_LIMIT);

   // ---------------- configuration ----------------
   logic [GW-1:0]                   grid_ff;
   logic [wss_pkg::TENSION_W-1:0]   tension_ff;
   logic [wss_pkg::DAMPING_W-1:0]   damping_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff    <= GW'(wss_pkg::GRID_RESET);
         tension_ff <= wss_pkg::TENSION_W'(wss_pkg::TENSION_RESET);
         damping_ff <= wss_pkg::DAMPING_W'(wss_pkg::DAMPING_RESET);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            wss_pkg::CSR_GRID_SIZE: grid_ff    <= csr_wr_data[GW-1:0];
            wss_pkg::CSR_TENSION:   tension_ff <= csr_wr_data[wss_pkg::TENSION_W-1:0];
            wss_pkg::CSR_DAMPING:   damping_ff <= csr_wr_data;
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   // clamped working values
   logic [GW-1:0]                 n_eff;
   logic [wss_pkg::TENSION_W-1:0] t_eff;

   always_comb begin
      if (grid_ff < GW'(wss_pkg::GRID_MIN))      n_eff = GW'(wss_pkg::GRID_MIN);
      else if (grid_ff > GW'(wss_pkg::MAX_GRID)) n_eff = GW'(wss_pkg::MAX_GRID);
      else                                       n_eff = grid_ff;
      if (tension_ff < wss_pkg::TENSION_W'(wss_pkg::TENSION_MIN))
         t_eff = wss_pkg::TENSION_W'(wss_pkg::TENSION_MIN);
      else if (tension_ff > wss_pkg::TENSION_W'(wss_pkg::TENSION_MAX))
         t_eff = wss_pkg::TENSION_W'(wss_pkg::TENSION_MAX);
      else
         t_eff = tension_ff;
   end

   // ---------------- sequencer and position ----------------
   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] row_ff, row_in, col_ff, col_in;
   logic [AW-1:0] item_row_ff, item_col_ff;
   logic signed [HW-1:0] cur_ff, prv_ff;
   logic          req_fire, out_free;
   logic [AW-1:0] pos_row, pos_col;
   logic [GW-1:0] col_inc, row_inc;
   logic [AW-1:0] row_wrap;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign pos_row   = req_frame_start ? '0 : row_ff;
   assign pos_col   = req_frame_start ? '0 : col_ff;

   always_comb begin
      col_inc  = GW'(pos_col) + GW'(1);
      row_inc  = GW'(pos_row) + GW'(1);
      row_wrap = pos_row;
      col_in   = col_ff;
      row_in   = row_ff;
      if (req_fire) begin
         if (col_inc >= n_eff) begin
            col_in   = '0;
            row_wrap = (row_inc >= n_eff) ? '0 : row_inc[AW-1:0];
         end else begin
            col_in = col_inc[AW-1:0];
         end
         // row left beyond a lowered grid size wraps
         row_in = (GW'(row_wrap) >= n_eff) ? '0 : row_wrap;
      end
   end

   // ---------------- line buffer memory ----------------
   logic [wss_pkg::WORD_W-1:0] line_mem [wss_pkg::MAX_GRID];
   logic [wss_pkg::WORD_W-1:0] rd_word_ff;
   logic [GW-1:0]              fill_ff, fill_in;
   logic                       mem_we;
   logic [wss_pkg::WORD_W-1:0] wr_word;

   always_ff @(posedge clock) begin
      if (req_fire) rd_word_ff <= line_mem[pos_col];
   end

   always_ff @(posedge clock) begin
      if (mem_we) line_mem[item_col_ff] <= wr_word;
   end

   // ---------------- window stage ----------------
   logic signed [HW-1:0] win_ff [6];
   logic signed [HW-1:0] win_in [6];
   logic signed [HW-1:0] spill_ff, spill_in;
   logic signed [HW-1:0] n0, n1, pd;
   logic                 entry_valid;
   logic signed [17:0]   orth, diag;
   logic signed [16:0]   t_s;
   logic signed [20:0]   k3;
   logic signed [34:0]   prod_orth, prod_diag;
   logic signed [36:0]   prod_u;
   logic signed [37:0]   p_orth_ff, p_diag_ff, p_u_ff, p_prev_ff;
   logic signed [37:0]   ctr_ext;
   logic                 emit_w, border_w, last_w;
   logic                 border_ff, last_ff;

   assign entry_valid = GW'(item_col_ff) < fill_ff;
   assign n0 = entry_valid ? rd_word_ff[3*HW-1:2*HW] : '0;
   assign n1 = entry_valid ? rd_word_ff[2*HW-1:HW]   : '0;
   assign pd = entry_valid ? rd_word_ff[HW-1:0]      : '0;

   assign mem_we  = (state_ff == S_WIN);
   assign wr_word = {n1, cur_ff, prv_ff};

   // writes advance through the buffer from entry zero, so a count suffices
   always_comb begin
      fill_in = fill_ff;
      if (mem_we && !entry_valid) fill_in = GW'(item_col_ff) + GW'(1);
   end

   always_comb begin
      for (int i = 0; i < 6; i++) win_in[i] = win_ff[i];
      spill_in = spill_ff;
      if (mem_we) begin
         win_in[0] = win_ff[3];
         win_in[1] = win_ff[4];
         win_in[2] = win_ff[5];
         win_in[3] = n0;
         win_in[4] = n1;
         win_in[5] = cur_ff;
         spill_in  = pd;
      end
   end

   assign orth = 18'(win_ff[1]) + 18'(n1) + 18'(win_ff[3]) + 18'(win_ff[5]);
   assign diag = 18'(win_ff[0]) + 18'(win_ff[2]) + 18'(n0) + 18'(cur_ff);
   assign t_s  = signed'({2'b00, t_eff});
   assign k3   = 21'sd786432 - (21'(t_s) * 21'sd20);
   assign prod_orth = t_s * orth;
   assign prod_diag = t_s * diag;
   assign prod_u    = k3 * win_ff[4];
   assign ctr_ext   = 38'(spill_ff);  // centre's previous height

   // centre sits one row and one column behind the request position
   assign emit_w   = (item_row_ff >= AW'(2)) ||
                     ((item_row_ff == AW'(1)) && (item_col_ff >= AW'(1)));
   assign border_w = (item_col_ff <= AW'(1)) || (item_row_ff == AW'(1)) ||
                     (GW'(item_col_ff) >= n_eff) || (GW'(item_row_ff) >= n_eff);
   assign last_w   = (GW'(item_row_ff) == n_eff - GW'(1)) &&
                     (GW'(item_col_ff) == n_eff - GW'(1));

   // ---------------- arithmetic chain ----------------
   logic signed [37:0] acc_ff;
   logic signed [16:0] d_s;
   logic signed [54:0] prod_ff, y_sum;
   logic signed [23:0] x_wide;
   logic [22:0]        x_ff;
   logic [45:0]        q_prod;
   logic signed [22:0] q_ff, q_sat;

   assign d_s    = signed'({1'b0, damping_ff});
   assign y_sum  = prod_ff + ROUND_BIAS;
   assign x_wide = 24'(signed'(y_sum[54:33])) + DIV_OFFSET;
   assign q_prod = 46'(x_ff) * 46'(wss_pkg::RECIP3);

   always_comb begin
      if (q_ff > SAT_HI)      q_sat = SAT_HI;
      else if (q_ff < SAT_LO) q_sat = SAT_LO;
      else                    q_sat = q_ff;
   end

   // ---------------- response register ----------------
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [HW-1:0] rsp_height_ff;
   logic                 rsp_last_ff;
   logic                 rsp_load;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = (state_ff == S_OUT) && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_WIN;
         S_WIN:   state_in = emit_w ? S_SUM : S_IDLE;
         S_SUM:   state_in = S_MUL;
         S_MUL:   state_in = S_SCALE;
         S_SCALE: state_in = S_DIV;
         S_DIV:   state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         fill_ff      <= '0;
         spill_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         fill_ff      <= fill_in;
         spill_ff     <= spill_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 6; i++) win_ff[i] <= win_in[i];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cur_ff      <= req_cur_height;
         prv_ff      <= req_prev_height;
         item_row_ff <= pos_row;
         item_col_ff <= pos_col;
      end
      if (state_ff == S_WIN) begin
         p_orth_ff <= 38'(prod_orth) <<< 2;
         p_diag_ff <= 38'(prod_diag);
         p_u_ff    <= 38'(prod_u);
         p_prev_ff <= (ctr_ext <<< 18) + (ctr_ext <<< 17);  // times 393216
         border_ff <= border_w;
         last_ff   <= last_w;
      end
      if (state_ff == S_SUM)   acc_ff  <= p_orth_ff + p_diag_ff + p_u_ff - p_prev_ff;
      if (state_ff == S_MUL)   prod_ff <= acc_ff * d_s;
      if (state_ff == S_SCALE) x_ff    <= x_wide[22:0];
      if (state_ff == S_DIV)
         q_ff <= signed'({1'b0, q_prod[45:wss_pkg::RECIP3_SHIFT]}) - DIV_BASE;
      if (rsp_load) begin
         rsp_height_ff <= border_ff ? '0 : q_sat[HW-1:0];
         rsp_last_ff   <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_height = rsp_height_ff;
   assign rsp_frame_last  = rsp_last_ff;

endmodule

>>> sv/wss_port_checker.sv
`timescale 1ns / 1ps
// Port-level checks for wave_stencil_step_unit, attached by bind.
// Depends on wss_pkg.
module wss_port_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic signed [wss_pkg::HEIGHT_W-1:0] req_cur_height,
   input logic signed [wss_pkg::HEIGHT_W-1:0] req_prev_height,
   input logic                                req_frame_start,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [wss_pkg::HEIGHT_W-1:0] rsp_next_height,
   input logic                                rsp_frame_last,
   input logic                                csr_wr_en,
   input logic [wss_pkg::CSR_INDEX_W-1:0]     csr_index,
   input logic [wss_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_next_height) && $stable(rsp_frame_last))
      else $error("stalled response changed");

   // one request in flight: ready drops after an accepted request
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while one is in flight");

   // saturation bound on every response
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_next_height <= wss_pkg::HEIGHT_LIMIT) &&
                    (rsp_next_height >= -wss_pkg::HEIGHT_LIMIT))
      else $error("response height beyond saturation limit");

   // reset leaves an empty, ready unit
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("unit not idle after reset");

endmodule

bind wave_stencil_step_unit wss_port_checker u_port_checker (.*);

>>> test/wave_stencil_step_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for wave_stencil_step_unit: streams raster cells, predicts
// each lagged stencil result in a local model of the unit and checks every response.
// Depends on wss_pkg and wave_stencil_step_unit.
module wave_stencil_step_unit_tb;
   import wss_pkg::*;

   localparam int  CYCLE_LIMIT   = 600000;
   localparam int  SETTLE_CYCLES = 16;      // longer than a request takes to reach the response register
   localparam int  DRAIN_LIMIT   = 5000;
   localparam int  HOLD_AT       = 120;     // requests accepted before the long hold
   localparam int  HOLD_CYCLES   = 400;
   // the update is carried as 6 * 2^16 times its true value
   localparam longint UPDATE_SCALE = 6 * 65536;

   localparam logic signed [HEIGHT_W-1:0] EDGE_HEIGHTS [8] = '{
      16'sd0, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384, 16'sd32767, -16'sd32768, 16'sh5555
   };

   typedef struct {
      logic signed [HEIGHT_W-1:0] cur_height;
      logic signed [HEIGHT_W-1:0] prev_height;
      logic                       frame_start;
   } cell_t;

   typedef struct {
      logic signed [HEIGHT_W-1:0] next_height;
      logic                       frame_last;
   } height_result_t;

   // DUT ports; the inputs are known from time zero
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [HEIGHT_W-1:0]   req_cur_height = '0;
   logic signed [HEIGHT_W-1:0]   req_prev_height = '0;
   logic                         req_frame_start = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic signed [HEIGHT_W-1:0]   rsp_next_height;
   logic                         rsp_frame_last;
   logic                         csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]       csr_index = CSR_GRID_SIZE;
   logic [CSR_DATA_W-1:0]        csr_wr_data = '0;

   // Stimulus and checking state
   cell_t          cell_q[$];          // cells waiting to be offered
   height_result_t next_height_q[$];   // predicted responses, oldest first
   int             mismatches = 0;
   int             accepted_cells = 0;
   int             cycle_count = 0;
   int             send_pause = 0;
   int             take_pause = 0;
   bit             send_steady = 1'b0;
   bit             take_steady = 1'b0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;

   // Local copy of the unit's register file and stream state
   logic [GRID_W-1:0]    grid_reg;
   logic [TENSION_W-1:0] tension_reg;
   logic [DAMPING_W-1:0] damping_reg;
   int                   line_heights [0:2*MAX_GRID-1];  // row r-2 then row r-1
   int                   prev_line    [0:MAX_GRID];      // delay line plus spill slot
   int                   window       [0:5];             // columns c-2 and c-1
   int unsigned          col_pos;
   int unsigned          row_pos;

   wave_stencil_step_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cur_height  (req_cur_height),
      .req_prev_height (req_prev_height),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_height (rsp_next_height),
      .rsp_frame_last  (rsp_frame_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // Damped nine-point update, round to nearest (ties up), saturated to +-4.0
   function automatic logic signed [HEIGHT_W-1:0] damped_update(
      input longint orth, input longint diag, input longint u, input longint prv);
      longint t, acc, num, den, q;
      t = tension_reg;
      if (t < TENSION_MIN) t = TENSION_MIN;
      if (t > TENSION_MAX) t = TENSION_MAX;
      acc = 4 * t * orth + t * diag + (2 * UPDATE_SCALE - 20 * t) * u - UPDATE_SCALE * prv;
      num = acc * longint'(damping_reg) + (longint'(3) <<< 32);
      den = longint'(3) <<< 33;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;   // floor, not truncation
      if (q > HEIGHT_LIMIT) q = HEIGHT_LIMIT;
      if (q < -HEIGHT_LIMIT) q = -HEIGHT_LIMIT;
      return q[HEIGHT_W-1:0];
   endfunction

   task automatic clear_stencil_state();
      grid_reg    = GRID_RESET;
      tension_reg = TENSION_RESET;
      damping_reg = DAMPING_RESET;
      foreach (line_heights[i]) line_heights[i] = 0;
      foreach (prev_line[i]) prev_line[i] = 0;
      foreach (window[i]) window[i] = 0;
      col_pos = 0;
      row_pos = 0;
   endtask

   // Advance the local stencil by one accepted cell; queue the response it causes
   task automatic predict_cell(input logic signed [HEIGHT_W-1:0] cur,
                               input logic signed [HEIGHT_W-1:0] prv,
                               input logic start);
      int unsigned    n, r, c;
      int             cur_v, above2, above1, centre_prev, orth, diag;
      height_result_t res;
      n = grid_reg;
      if (n < GRID_MIN) n = GRID_MIN;
      if (n > MAX_GRID) n = MAX_GRID;
      cur_v = cur;
      if (start) begin
         col_pos = 0;
         row_pos = 0;
      end
      r = row_pos;
      c = col_pos % MAX_GRID;
      above2 = line_heights[c];
      above1 = line_heights[MAX_GRID + c];
      // previous height of the centre, one row plus one cell late
      centre_prev = prev_line[MAX_GRID];
      prev_line[MAX_GRID] = prev_line[c];
      prev_line[c] = prv;
      if (r >= 2 || (r == 1 && c >= 1)) begin
         res.next_height = '0;
         // centre sits at (r-1, c-1); anything on or past the edge is border
         if (!(c <= 1 || r == 1 || c - 1 >= n - 1 || r - 1 >= n - 1)) begin
            orth = window[1] + above1 + window[3] + window[5];
            diag = window[0] + window[2] + above2 + cur_v;
            res.next_height = damped_update(orth, diag, window[4], centre_prev);
         end
         res.frame_last = (r == n - 1 && col_pos == n - 1);
         next_height_q.push_back(res);
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = above2;
      window[4] = above1;
      window[5] = cur_v;
      line_heights[c] = above1;
      line_heights[MAX_GRID + c] = cur_v;
      if (col_pos + 1 >= n) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= n) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      if (row_pos >= n) row_pos = 0;
   endtask

   function automatic int pick_pause(input bit steady);
      int k;
      if (steady) return 0;
      k = $urandom_range(0, 99);
      if (k < 60) return 0;
      if (k < 88) return $urandom_range(1, 3);
      if (k < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly small smooth-ish heights, some full range, some raw 16-bit and edge values
   function automatic logic signed [HEIGHT_W-1:0] rand_height();
      int k, v;
      k = $urandom_range(0, 99);
      if (k < 55) begin
         v = $urandom_range(0, 2048);
         return v - 1024;
      end
      if (k < 85) begin
         v = $urandom_range(0, 2 * HEIGHT_LIMIT);
         return v - HEIGHT_LIMIT;
      end
      if (k < 95) return $urandom_range(0, 65535);
      return EDGE_HEIGHTS[$urandom_range(0, 7)];
   endfunction

   // Raster cells; noisy streams now and then drop a stray frame marker mid frame
   task automatic queue_cells(input int count, input bit marker, input bit noisy);
      cell_t item;
      for (int i = 0; i < count; i++) begin
         item.cur_height  = rand_height();
         item.prev_height = rand_height();
         item.frame_start = (i == 0 && marker) || (noisy && $urandom_range(0, 799) == 0);
         cell_q.push_back(item);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_GRID_SIZE: grid_reg    = value[GRID_W-1:0];
         CSR_TENSION:   tension_reg = value[TENSION_W-1:0];
         CSR_DAMPING:   damping_reg = value[DAMPING_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CSR_DATA_W-1:0] grid,
                            input logic [CSR_DATA_W-1:0] tension,
                            input logic [CSR_DATA_W-1:0] damping);
      write_csr(CSR_GRID_SIZE, grid);
      write_csr(CSR_TENSION, tension);
      write_csr(CSR_DAMPING, damping);
   endtask

   // Wait until every request is in and every response is back, then let the
   // pipeline empty out (a cell with no response may still be in flight)
   task automatic settle();
      int waited;
      waited = 0;
      while (cell_q.size() != 0 || req_valid) @(posedge clock);
      while (next_height_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (next_height_q.size() != 0) begin
         report($sformatf("%0d responses never arrived", next_height_q.size()));
         next_height_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: offers queued cells with random gaps, predicts on acceptance
   always @(posedge clock) begin : drive_cells
      cell_t item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_cell(req_cur_height, req_prev_height, req_frame_start);
            accepted_cells <= accepted_cells + 1;
         end
         // payload holds while an offer is pending
         if (!req_valid || req_ready) begin
            if (send_pause > 0) begin
               send_pause--;
               req_valid <= 1'b0;
            end else if (cell_q.size() != 0) begin
               item = cell_q.pop_front();
               req_valid       <= 1'b1;
               req_cur_height  <= item.cur_height;
               req_prev_height <= item.prev_height;
               req_frame_start <= item.frame_start;
               if ($urandom_range(0, 99) == 0) send_steady = !send_steady;
               send_pause = pick_pause(send_steady);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off once, well into the first random phase, so the unit
   // backs up and refuses requests while the driver keeps offering
   always @(posedge clock) begin : long_hold
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && accepted_cells >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end
      end
   end

   // Response side back-pressure
   always @(posedge clock) begin : take_results
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
      end else if (take_pause > 0) begin
         take_pause--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) == 0) take_steady = !take_steady;
         take_pause = ($urandom_range(0, 2) == 0) ? pick_pause(take_steady) : 0;
      end
   end

   // Response checker: in-order compare against the oldest prediction
   always @(posedge clock) begin : check_results
      height_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (next_height_q.size() == 0) begin
            report($sformatf("unexpected response next_height=%0d frame_last=%0b",
                             rsp_next_height, rsp_frame_last));
         end else begin
            want = next_height_q.pop_front();
            if (rsp_next_height !== want.next_height)
               report($sformatf("next_height got %0d want %0d",
                                rsp_next_height, want.next_height));
            if (rsp_frame_last !== want.frame_last)
               report($sformatf("frame_last got %0b want %0b",
                                rsp_frame_last, want.frame_last));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[wave_stencil_step_unit] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      cell_t item;
      clear_stencil_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: smallest grid, reset coefficients, edge heights on both inputs.
      // Covers the silent start of frame, the border row and a mid-frame marker.
      write_csr(CSR_GRID_SIZE, GRID_MIN);
      for (int i = 0; i < 25; i++) begin
         item.cur_height  = EDGE_HEIGHTS[i % 8];
         item.prev_height = EDGE_HEIGHTS[(i + 3) % 8];
         item.frame_start = (i == 0) || (i == 21);
         cell_q.push_back(item);
      end
      settle();

      // Low tension and damping limits; one clean frame for frame_last, then a
      // few cells of the next one. The long hold lands in here.
      write_all(16, TENSION_MIN, 57213);
      queue_cells(GRID_MIN * GRID_MIN + 20, 1'b1, 1'b0);
      settle();

      // Oversized grid clamps to the maximum; tension above range, zero damping.
      // Enough cells to pass the silent start and get the first responses, all border.
      write_all(16'hFFFF, 16'hFFFF, 16'h0000);
      queue_cells(530, 1'b1, 1'b0);
      settle();

      // Shrink the grid under the current position: a column beyond the grid,
      // then a frame of 17 stopped on row 16 before shrinking again to 16
      write_all(17, 16'h0000, 16'hFFFF);
      queue_cells(3, 1'b0, 1'b0);
      queue_cells(17 * 16 + 5, 1'b1, 1'b0);
      settle();
      write_csr(CSR_GRID_SIZE, 16);
      queue_cells(100, 1'b0, 1'b1);
      settle();

      // Undersized grid clamps to the minimum; top of the tension range
      write_all(16'h0000, TENSION_MAX, 65438);
      queue_cells(GRID_MIN * GRID_MIN, 1'b1, 1'b1);
      settle();

      // Random settings in range, one noisy frame plus a short tail
      write_all($urandom_range(16, 20), $urandom_range(TENSION_MIN, TENSION_MAX),
                $urandom_range(57213, 65438));
      queue_cells(grid_reg * grid_reg + $urandom_range(0, 30), 1'b1, 1'b1);
      settle();

      if (mismatches == 0) begin
         $display("[wave_stencil_step_unit] OK");
      end else begin
         $display("[wave_stencil_step_unit] ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/wss_pkg.sv
sv/wave_stencil_step_unit.sv
sv/wss_port_checker.sv
test/wave_stencil_step_unit_tb.sv
